FILE: rtl/core/js_string_literal_unescaper_defines.svh
// Assertion macros shared by the checker of the string literal unescaper.
// Depends on nothing; the checker supplies clk_i and rst_ni by name.
`ifndef JS_STRING_LITERAL_UNESCAPER_DEFINES_SVH
`define JS_STRING_LITERAL_UNESCAPER_DEFINES_SVH
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define JSLU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define JSLU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/core/jslu_pkg.sv
// Shared types and constants of the string literal unescaper.
// Depends on nothing; every module of the block uses it.
package jslu_pkg;

  localparam int unsigned MaxRes    = 7;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;

  typedef enum logic [1:0] {
    StData   = 2'd0,
    StClosed = 2'd1,
    StError  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } out_t;

  // All results caused by one input item; only the final one may carry a
  // non-data status.
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [2:0]             cnt;
    status_e                status;
  } bundle_t;

  typedef struct packed {
    logic pop;
  } q_ctl_t;

endpackage

FILE: rtl/core/jslu_fifo.sv
// Short queue of result bundles between the decoder front and the serializer.
// Depends on jslu_pkg.
module jslu_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jslu_pkg::bundle_t data_i,
  output logic             full_o,
  input  jslu_pkg::q_ctl_t ctl_i,
  output logic             head_valid_o,
  output jslu_pkg::bundle_t head_o
);

  jslu_pkg::bundle_t mem_q [jslu_pkg::FifoDepth];
  logic [jslu_pkg::FifoPtrW-1:0] wr_q, rd_q;
  logic [jslu_pkg::FifoPtrW:0]   cnt_q;
  logic do_pop;

  assign full_o       = (cnt_q == (jslu_pkg::FifoPtrW + 1)'(jslu_pkg::FifoDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_pop       = ctl_i.pop & head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (push_i && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: rtl/core/jslu_front.sv
// Decoder front: classifies each source byte and builds its result bundle.
// Depends on jslu_pkg.
module jslu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  jslu_pkg::in_t     in_i,
  output logic              bundle_valid_o,
  output jslu_pkg::bundle_t bundle_o
);

  typedef enum logic [9:0] {
    PhIdle    = 10'b0000000001,
    PhBody    = 10'b0000000010,
    PhEsc     = 10'b0000000100,
    PhEscLs   = 10'b0000001000,
    PhXhex    = 10'b0000010000,
    PhUstart  = 10'b0000100000,
    PhU4      = 10'b0001000000,
    PhUbrace  = 10'b0010000000,
    PhSurWait = 10'b0100000000,
    PhSurBs   = 10'b1000000000
  } phase_e;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } enc_t;

  function automatic logic [4:0] hexval(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic enc_t encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.len = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.len = 3'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.len = 3'd3;
      e.bytes[0] = {4'hE, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.len = 3'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  phase_e      phase_q, phase_d;
  logic        apos_q, apos_d;
  logic [20:0] acc_q, acc_d;
  logic        ovf_q, ovf_d;
  logic [2:0]  dcnt_q, dcnt_d;
  logic [9:0]  pend_q, pend_d;
  logic        pend_v_q, pend_v_d;
  logic [1:0]  held_q, held_d;
  logic        cr_q, cr_d;
  logic        second_q, second_d;

  logic [jslu_pkg::MaxRes-1:0][7:0] ob;
  logic [2:0]        on;
  jslu_pkg::status_e ost;
  logic [7:0]  b;
  logic [4:0]  hv;
  logic [24:0] nval;
  logic        do_flush, do_esc, do_body, do_finish, do_fail, do_close, do_clear;
  logic        join_low, skip;
  logic [20:0] fin_cp;
  enc_t        enc_f, enc_m;

  always_comb begin
    phase_d  = phase_q;
    apos_d   = apos_q;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    dcnt_d   = dcnt_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    held_d   = held_q;
    cr_d     = cr_q;
    second_d = second_q;
    ob   = '0;
    on   = 3'd0;
    ost  = jslu_pkg::StData;
    b    = in_i.in_byte;
    hv   = hexval(b);
    nval = {acc_q, hv[3:0]};
    do_flush = 1'b0; do_esc = 1'b0; do_body = 1'b0; do_finish = 1'b0;
    do_fail = 1'b0; do_close = 1'b0; do_clear = 1'b0;
    join_low = 1'b0; skip = 1'b0;
    fin_cp = acc_q;
    enc_f = encode(21'hD800 + 21'(pend_q));
    enc_m = '0;

    if (in_i.end_of_text) begin
      if (phase_q != PhIdle) do_fail = 1'b1;
    end else begin
      case (phase_q)
        PhIdle: begin
          if (b == 8'h27 || b == 8'h22) begin
            do_clear = 1'b1;
          end else begin
            do_fail = 1'b1;
          end
        end
        PhBody: do_body = 1'b1;
        PhEsc:  do_esc = 1'b1;
        PhEscLs: begin
          if (held_q == 2'd1) begin
            if (b == 8'h80) begin
              held_d = 2'd2;
            end else begin
              ob[on] = 8'hE2; on = on + 3'd1;
              held_d = 2'd0; phase_d = PhBody; do_body = 1'b1;
            end
          end else begin
            held_d = 2'd0;
            phase_d = PhBody;
            if (!(b == 8'hA8 || b == 8'hA9)) begin
              ob[on] = 8'hE2; on = on + 3'd1;
              ob[on] = 8'h80; on = on + 3'd1;
              do_body = 1'b1;
            end
          end
        end
        PhXhex: begin
          if (!hv[4]) begin
            do_fail = 1'b1;
          end else begin
            acc_d  = {13'd0, acc_q[3:0], hv[3:0]};
            dcnt_d = dcnt_q + 3'd1;
            if (dcnt_q >= 3'd1) begin
              ob[on] = acc_d[7:0]; on = on + 3'd1;
              phase_d = PhBody;
            end
          end
        end
        PhUstart: begin
          if (hv[4]) begin
            acc_d = {17'd0, hv[3:0]}; dcnt_d = 3'd1; phase_d = PhU4;
          end else if (b == 8'h7B) begin
            acc_d = '0; dcnt_d = 3'd0; ovf_d = 1'b0; phase_d = PhUbrace;
          end else begin
            do_fail = 1'b1;
          end
        end
        PhU4: begin
          if (!hv[4]) begin
            do_fail = 1'b1;
          end else begin
            acc_d  = {5'd0, acc_q[11:0], hv[3:0]};
            dcnt_d = dcnt_q + 3'd1;
            if (dcnt_q >= 3'd3) begin
              do_finish = 1'b1;
              fin_cp = acc_d;
            end
          end
        end
        PhUbrace: begin
          if (hv[4]) begin
            if (nval > 25'h10FFFF) ovf_d = 1'b1;
            acc_d = nval[20:0];
            if (dcnt_q < 3'd7) dcnt_d = dcnt_q + 3'd1;
          end else if (b == 8'h7D && dcnt_q != 3'd0 && !ovf_q) begin
            do_finish = 1'b1;
          end else begin
            do_fail = 1'b1;
          end
        end
        PhSurWait: begin
          if (b == 8'h5C) begin
            phase_d = PhSurBs;
          end else begin
            do_flush = 1'b1; phase_d = PhBody; do_body = 1'b1;
          end
        end
        PhSurBs: begin
          if (b == 8'h75) begin
            second_d = 1'b1; phase_d = PhUstart;
          end else begin
            do_flush = 1'b1; do_esc = 1'b1;
          end
        end
        default: do_clear = 1'b1;
      endcase
    end

    // A finished code point that cannot pair with the pending high half
    // first pushes that half out on its own.
    if (do_finish && second_q && pend_v_q) begin
      if (fin_cp >= 21'hDC00 && fin_cp <= 21'hDFFF) join_low = 1'b1;
      else do_flush = 1'b1;
    end

    if (do_flush) begin
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < enc_f.len) begin
          ob[on] = enc_f.bytes[k]; on = on + 3'd1;
        end
      end
      pend_v_d = 1'b0;
      pend_d   = '0;
    end

    if (do_esc) begin
      phase_d = PhBody;
      case (b)
        8'h0A: ;
        8'h0D: cr_d = 1'b1;
        8'hE2: begin phase_d = PhEscLs; held_d = 2'd1; end
        8'h62: begin ob[on] = 8'h08; on = on + 3'd1; end
        8'h66: begin ob[on] = 8'h0C; on = on + 3'd1; end
        8'h6E: begin ob[on] = 8'h0A; on = on + 3'd1; end
        8'h72: begin ob[on] = 8'h0D; on = on + 3'd1; end
        8'h74: begin ob[on] = 8'h09; on = on + 3'd1; end
        8'h76: begin ob[on] = 8'h0B; on = on + 3'd1; end
        8'h78: begin phase_d = PhXhex; acc_d = '0; dcnt_d = 3'd0; end
        8'h75: begin phase_d = PhUstart; second_d = pend_v_d; end
        default: begin ob[on] = b; on = on + 3'd1; end
      endcase
    end

    if (do_finish) begin
      second_d = 1'b0;
      if (join_low) begin
        enc_m    = encode(21'h10000 + {1'b0, pend_q, fin_cp[9:0]});
        pend_v_d = 1'b0;
        pend_d   = '0;
        phase_d  = PhBody;
      end else if (fin_cp >= 21'hD800 && fin_cp <= 21'hDBFF) begin
        pend_d   = fin_cp[9:0];
        pend_v_d = 1'b1;
        phase_d  = PhSurWait;
      end else begin
        enc_m   = encode(fin_cp);
        phase_d = PhBody;
      end
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < enc_m.len) begin
          ob[on] = enc_m.bytes[k]; on = on + 3'd1;
        end
      end
    end

    if (do_body) begin
      if (cr_d) begin
        cr_d = 1'b0;
        if (b == 8'h0A) skip = 1'b1;
      end
      if (!skip) begin
        if (held_d == 2'd1) begin
          if (b == 8'h80) begin
            held_d = 2'd2; skip = 1'b1;
          end else begin
            ob[on] = 8'hE2; on = on + 3'd1; held_d = 2'd0;
          end
        end else if (held_d == 2'd2) begin
          if (b == 8'hA8 || b == 8'hA9) begin
            do_fail = 1'b1; skip = 1'b1;
          end else begin
            ob[on] = 8'hE2; on = on + 3'd1;
            ob[on] = 8'h80; on = on + 3'd1;
            held_d = 2'd0;
          end
        end
      end
      if (!skip) begin
        if (b == (apos_q ? 8'h27 : 8'h22)) do_close = 1'b1;
        else if (b == 8'h5C) phase_d = PhEsc;
        else if (b == 8'h0A || b == 8'h0D) do_fail = 1'b1;
        else if (b == 8'hE2) held_d = 2'd1;
        else begin ob[on] = b; on = on + 3'd1; end
      end
    end

    if (do_fail || do_close) begin
      ob[on] = 8'h00; on = on + 3'd1;
      ost = do_fail ? jslu_pkg::StError : jslu_pkg::StClosed;
      do_clear = 1'b1;
    end

    if (do_clear) begin
      phase_d = PhIdle; apos_d = 1'b0; acc_d = '0; ovf_d = 1'b0; dcnt_d = '0;
      pend_d = '0; pend_v_d = 1'b0; held_d = '0; cr_d = 1'b0; second_d = 1'b0;
      if (!in_i.end_of_text && phase_q == PhIdle && !do_fail) begin
        apos_d  = (b == 8'h27);
        phase_d = PhBody;
      end
    end
  end

  assign bundle_valid_o  = in_valid_i && (on != 3'd0);
  assign bundle_o.bytes  = ob;
  assign bundle_o.cnt    = on;
  assign bundle_o.status = ost;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; apos_q <= 1'b0; acc_q <= '0; ovf_q <= 1'b0; dcnt_q <= '0;
      pend_q <= '0; pend_v_q <= 1'b0; held_q <= '0; cr_q <= 1'b0; second_q <= 1'b0;
    end else if (in_valid_i) begin
      phase_q <= phase_d; apos_q <= apos_d; acc_q <= acc_d; ovf_q <= ovf_d;
      dcnt_q <= dcnt_d; pend_q <= pend_d; pend_v_q <= pend_v_d; held_q <= held_d;
      cr_q <= cr_d; second_q <= second_d;
    end
  end

endmodule

FILE: rtl/core/jslu_back.sv
// Serializer back: hands out the results of the head bundle one per transfer.
// Depends on jslu_pkg.
module jslu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  jslu_pkg::bundle_t head_i,
  input  logic              pop_i,
  output jslu_pkg::q_ctl_t  ctl_o,
  output logic              empty_o,
  output jslu_pkg::out_t    out_o
);

  logic [2:0] idx_q, idx_d;
  logic       is_last, take;

  assign empty_o  = !head_valid_i;
  assign is_last  = (idx_q == head_i.cnt - 3'd1);
  assign take     = pop_i && head_valid_i;

  assign out_o.out_byte = head_i.bytes[idx_q];
  assign out_o.status   = is_last ? head_i.status : jslu_pkg::StData;
  assign out_o.last     = is_last;

  assign ctl_o.pop = take && is_last;

  always_comb begin
    idx_d = idx_q;
    if (take) idx_d = is_last ? 3'd0 : idx_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

FILE: rtl/core/js_string_literal_unescaper.sv
// A source byte is decoded combinationally; its results are registered in the bundle queue.
// Throughput: one source byte per cycle while the result side keeps pace; results leave at
// one per cycle while pop is high, and a byte that expands to N results takes N transfers.
// A four-entry bundle queue absorbs such bursts before full rises.
// Reset: rst_ni low clears the decoder state to idle and empties the queue at once.
module js_string_literal_unescaper (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  jslu_pkg::in_t  in_i,
  output logic           empty,
  input  logic           pop,
  output jslu_pkg::out_t out_o
);

  // The front decodes one byte per transfer into a bundle of up to seven
  // results. Bytes that produce nothing never enter the queue.
  logic              accept;
  logic              bundle_valid;
  jslu_pkg::bundle_t bundle;
  logic              head_valid;
  jslu_pkg::bundle_t head;
  jslu_pkg::q_ctl_t  ctl;

  assign accept = push && !full;

  jslu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (accept),
    .in_i           (in_i),
    .bundle_valid_o (bundle_valid),
    .bundle_o       (bundle)
  );

  // The queue decouples the two sides, so a stalled consumer does not stop
  // decoding until the queue is full.
  jslu_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (bundle_valid),
    .data_i       (bundle),
    .full_o       (full),
    .ctl_i        (ctl),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // The back walks through the head bundle one result per transfer and
  // releases the entry after its final result.
  jslu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_i        (pop),
    .ctl_o        (ctl),
    .empty_o      (empty),
    .out_o        (out_o)
  );

endmodule

FILE: rtl/core/jslu_checker.sv
// Port-level checker of the string literal unescaper, bound to the top level.
// Depends on jslu_pkg and js_string_literal_unescaper_defines.svh.
`include "js_string_literal_unescaper_defines.svh"
module jslu_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           push,
  input logic           full,
  input jslu_pkg::in_t  in_i,
  input logic           empty,
  input logic           pop,
  input jslu_pkg::out_t out_o
);

  `JSLU_ASSERT_IMPL(a_status_last, !empty && out_o.status != jslu_pkg::StData, out_o.last, "status result not last")
  `JSLU_ASSERT_IMPL(a_status_zero, !empty && out_o.status != jslu_pkg::StData, out_o.out_byte == 8'h00, "status result carries data")
  `JSLU_ASSERT_IMPL(a_status_code, !empty, out_o.status == jslu_pkg::StData || out_o.status == jslu_pkg::StClosed || out_o.status == jslu_pkg::StError, "bad status code")
  `JSLU_ASSERT_NEXT(a_burst_cont, pop && !empty && !out_o.last, !empty, "result burst broken")

endmodule

bind js_string_literal_unescaper jslu_checker u_jslu_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .in_i   (in_i),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);

FILE: tb/tb_js_string_literal_unescaper.sv
// Self-checking testbench for the string literal unescaper, top module last in the build.
// Depends on jslu_pkg for the transfer types; the decoder is predicted by a small scoreboard.
module tb_js_string_literal_unescaper;
  timeunit 1ns;
  timeprecision 1ps;

  import jslu_pkg::*;

  // Decoder phases of the predictor; the block keeps its own encoding.
  typedef enum logic [3:0] {
    PhIdle, PhBody, PhEsc, PhEscLs, PhXHex, PhUStart, PhU4, PhUBrace, PhSurWait, PhSurBs
  } dec_phase_e;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChApos   = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLsLead = 8'hE2;
  localparam int unsigned MaxShown = 10;

  // The scoreboard predicts the decoded bytes of every accepted source byte and
  // checks each popped result against the oldest prediction.
  class unescape_scoreboard;
    out_t       expected_q[$];
    out_t       burst[$];
    int         mismatches;
    dec_phase_e ph;
    bit         apos;
    logic [20:0] acc;
    bit         ovf;
    logic [2:0] ndig;
    logic [9:0] high_sur;
    bit         high_valid;
    logic [1:0] held;
    bit         after_cr;
    bit         second;

    function new();
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      ph = PhIdle;
      apos = 0;
      acc = '0;
      ovf = 0;
      ndig = '0;
      high_sur = '0;
      high_valid = 0;
      held = '0;
      after_cr = 0;
      second = 0;
    endfunction

    function void put(logic [7:0] b, status_e st);
      out_t o;
      if (burst.size() < MaxRes) begin
        o.out_byte = b;
        o.status = st;
        o.last = 1'b0;
        burst.push_back(o);
      end
    endfunction

    function void abandon();
      put(8'h00, StError);
      clear_state();
    endfunction

    function int hex_digit(logic [7:0] b);
      if (b >= "0" && b <= "9") return b - "0";
      if (b >= "a" && b <= "f") return b - "a" + 10;
      if (b >= "A" && b <= "F") return b - "A" + 10;
      return -1;
    endfunction

    function void utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
        put(cp[7:0], StData);
      end else if (cp < 21'h800) begin
        put({3'b110, cp[10:6]}, StData);
        put({2'b10, cp[5:0]}, StData);
      end else if (cp < 21'h10000) begin
        put({4'b1110, cp[15:12]}, StData);
        put({2'b10, cp[11:6]}, StData);
        put({2'b10, cp[5:0]}, StData);
      end else begin
        put({5'b11110, cp[20:18]}, StData);
        put({2'b10, cp[17:12]}, StData);
        put({2'b10, cp[11:6]}, StData);
        put({2'b10, cp[5:0]}, StData);
      end
    endfunction

    function void flush_high();
      utf8(21'hD800 + {11'd0, high_sur});
      high_valid = 0;
      high_sur = '0;
    endfunction

    // A completed \u escape: join with a waiting high surrogate, start a new wait, or emit it as UTF-8.
    function void code_point_done(logic [20:0] cp);
      if (second && high_valid) begin
        if (cp >= 21'hDC00 && cp <= 21'hDFFF) begin
          utf8((21'(high_sur) << 10) + (cp - 21'hDC00) + 21'h10000);
          high_valid = 0;
          high_sur = '0;
          second = 0;
          ph = PhBody;
          return;
        end
        flush_high();
      end
      second = 0;
      if (cp >= 21'hD800 && cp <= 21'hDBFF) begin
        high_sur = cp[9:0];
        high_valid = 1;
        ph = PhSurWait;
        return;
      end
      utf8(cp);
      ph = PhBody;
    endfunction

    function void string_byte(logic [7:0] b);
      if (after_cr) begin
        after_cr = 0;
        if (b == ChLf) return;
      end
      if (held == 2'd1) begin
        if (b == 8'h80) begin
          held = 2'd2;
          return;
        end
        put(ChLsLead, StData);
        held = '0;
      end else if (held == 2'd2) begin
        if (b == 8'hA8 || b == 8'hA9) begin
          abandon();
          return;
        end
        put(ChLsLead, StData);
        put(8'h80, StData);
        held = '0;
      end
      if (b == (apos ? ChApos : ChQuote)) begin
        put(8'h00, StClosed);
        clear_state();
        return;
      end
      if (b == ChBslash) begin
        ph = PhEsc;
        return;
      end
      if (b == ChLf || b == ChCr) begin
        abandon();
        return;
      end
      if (b == ChLsLead) begin
        held = 2'd1;
        return;
      end
      put(b, StData);
    endfunction

    function void escape_byte(logic [7:0] b);
      ph = PhBody;
      case (b)
        ChLf: ;
        ChCr: after_cr = 1;
        ChLsLead: begin
          ph = PhEscLs;
          held = 2'd1;
        end
        "b": put(8'h08, StData);
        "f": put(8'h0C, StData);
        "n": put(8'h0A, StData);
        "r": put(8'h0D, StData);
        "t": put(8'h09, StData);
        "v": put(8'h0B, StData);
        "x": begin
          ph = PhXHex;
          acc = '0;
          ndig = '0;
        end
        "u": begin
          ph = PhUStart;
          second = high_valid;
        end
        default: put(b, StData);
      endcase
    endfunction

    function void note_input(in_t it);
      logic [7:0]  b;
      int          d;
      logic [31:0] n;
      b = it.in_byte;
      burst.delete();
      if (it.end_of_text) begin
        if (ph != PhIdle) abandon();
      end else begin
        d = hex_digit(b);
        case (ph)
          PhIdle: begin
            if (b == ChApos || b == ChQuote) begin
              clear_state();
              apos = (b == ChApos);
              ph = PhBody;
            end else begin
              abandon();
            end
          end
          PhBody: string_byte(b);
          PhEsc: escape_byte(b);
          PhEscLs: begin
            if (held == 2'd1) begin
              if (b == 8'h80) begin
                held = 2'd2;
                return_burst();
                return;
              end
              put(ChLsLead, StData);
              held = '0;
              ph = PhBody;
              string_byte(b);
            end else if (b == 8'hA8 || b == 8'hA9) begin
              held = '0;
              ph = PhBody;
            end else begin
              put(ChLsLead, StData);
              put(8'h80, StData);
              held = '0;
              ph = PhBody;
              string_byte(b);
            end
          end
          PhXHex: begin
            if (d < 0) begin
              abandon();
            end else begin
              acc = {13'd0, acc[3:0], d[3:0]};
              ndig = ndig + 1;
              if (ndig >= 2) begin
                put(acc[7:0], StData);
                ph = PhBody;
              end
            end
          end
          PhUStart: begin
            if (d >= 0) begin
              acc = 21'(d);
              ndig = 3'd1;
              ph = PhU4;
            end else if (b == "{") begin
              acc = '0;
              ndig = '0;
              ovf = 0;
              ph = PhUBrace;
            end else begin
              abandon();
            end
          end
          PhU4: begin
            if (d < 0) begin
              abandon();
            end else begin
              acc = {5'd0, acc[11:0], d[3:0]};
              ndig = ndig + 1;
              if (ndig >= 4) code_point_done(acc);
            end
          end
          PhUBrace: begin
            if (d >= 0) begin
              n = {7'd0, acc, 4'd0} | 32'(d);
              if (n > 32'h10FFFF) ovf = 1;
              acc = n[20:0];
              if (ndig < 7) ndig = ndig + 1;
            end else if (b == "}" && ndig != 0 && !ovf) begin
              code_point_done(acc);
            end else begin
              abandon();
            end
          end
          PhSurWait: begin
            if (b == ChBslash) begin
              ph = PhSurBs;
            end else begin
              flush_high();
              ph = PhBody;
              string_byte(b);
            end
          end
          PhSurBs: begin
            if (b == "u") begin
              second = 1;
              ph = PhUStart;
            end else begin
              flush_high();
              escape_byte(b);
            end
          end
          default: clear_state();
        endcase
      end
      return_burst();
    endfunction

    // Marks the final result of the step and queues the whole burst.
    function void return_burst();
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) expected_q.push_back(burst[i]);
      burst.delete();
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("ERROR: unexpected result byte=%h status=%0d last=%b",
                   got.out_byte, got.status, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte || got.status !== want.status ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("ERROR: expected byte=%h status=%0d last=%b, got byte=%h status=%0d last=%b",
                   want.out_byte, want.status, want.last,
                   got.out_byte, got.status, got.last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  in_t  in_i = '0;
  out_t out_o;

  unescape_scoreboard sb = new();

  // Idle percentages of both sides; the receiver hold-off is requested by the
  // stimulus and counted down inside the receiver process.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request = 0;
  in_t         source_q[$];
  int          items_sent = 0;

  js_string_literal_unescaper dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .in_i  (in_i),
    .empty (empty),
    .pop   (pop),
    .out_o (out_o)
  );

  initial begin
    forever #10ns clk_i = ~clk_i;
  end

  // Generous fixed limit; the slowest correct run needs far less.
  initial begin
    #4ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: decides each transfer from values settled at the falling edge,
  // so nothing depends on ordering within the rising edge.
  initial begin
    out_t got;
    bit   take;
    int   hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      take = pop && !empty;
      got = out_o;
      @(posedge clk_i);
      if (take) sb.check_result(got);
      if (hold_request) begin
        hold_request = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one source byte until the block takes it, then records it.
  // Called right after a rising edge; leaves right after the edge of the transfer or after a random idle gap.
  task automatic send_byte(in_t it);
    bit ok;
    push <= 1'b1;
    in_i <= it;
    do begin
      @(negedge clk_i);
      ok = !full;
      @(posedge clk_i);
    end while (!ok);
    sb.note_input(it);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      in_i <= in_t'({$urandom_range(255), 1'($urandom_range(1))});
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic add(logic [7:0] b);
    source_q.push_back(in_t'{in_byte: b, end_of_text: 1'b0});
  endtask

  task automatic add_end_of_text();
    source_q.push_back(in_t'{in_byte: 8'($urandom_range(255)), end_of_text: 1'b1});
  endtask

  task automatic drain_source();
    while (source_q.size() > 0) send_byte(source_q.pop_front());
  endtask

  function automatic logic [7:0] hex_char(int unsigned v);
    logic [7:0] c;
    c = (v < 10) ? 8'("0" + v) : 8'("a" + v - 10);
    if (v >= 10 && $urandom_range(1)) c = c - 8'h20;
    return c;
  endfunction

  task automatic add_u4(logic [15:0] v);
    add(ChBslash);
    add("u");
    for (int i = 3; i >= 0; i--) add(hex_char(v[i*4 +: 4]));
  endtask

  // One random piece of string content; most are well formed, a few are broken.
  task automatic add_piece();
    int unsigned k;
    int unsigned nd;
    logic [27:0] v;
    case ($urandom_range(11))
      0: add(8'($urandom_range(8'h20, 8'h7E)));
      1: add(8'($urandom_range(255)));
      2: begin
        add(ChBslash);
        case ($urandom_range(9))
          0: add("b");
          1: add("f");
          2: add("n");
          3: add("r");
          4: add("t");
          5: add("v");
          6: add(ChQuote);
          7: add(ChApos);
          8: add(ChBslash);
          default: add(8'($urandom_range(255)));
        endcase
      end
      3: begin
        add(ChBslash);
        add("x");
        add(hex_char($urandom_range(15)));
        add($urandom_range(9) == 0 ? 8'("g") : hex_char($urandom_range(15)));
      end
      4: add_u4(16'($urandom_range(16'hFFFF)));
      5: begin
        nd = $urandom_range(7);
        v = 28'($urandom());
        if ($urandom_range(1)) v = 28'($urandom_range(21'h10FFFF));
        add(ChBslash);
        add("u");
        add("{");
        for (int i = 6; i >= 0; i--) if (i < nd) add(hex_char(v[i*4 +: 4]));
        if ($urandom_range(4) != 0) add("}");
      end
      6: begin
        add_u4(16'($urandom_range(16'hD800, 16'hDBFF)));
        add_u4(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end
      7: begin
        add_u4(16'($urandom_range(16'hD800, 16'hDBFF)));
        k = $urandom_range(3);
        if (k == 0) add("a");
        else if (k == 1) add_u4(16'($urandom_range(16'hD800, 16'hDBFF)));
        else if (k == 2) begin
          add(ChBslash);
          add("n");
        end else begin
          add(ChBslash);
          add("u");
          add("{");
          add("4");
          add("1");
          add("}");
        end
      end
      8: begin
        add(ChBslash);
        case ($urandom_range(4))
          0: add(ChLf);
          1: add(ChCr);
          2: begin
            add(ChCr);
            add(ChLf);
          end
          3: begin
            add(ChLsLead);
            add(8'h80);
            add($urandom_range(1) ? 8'hA8 : 8'hA9);
          end
          default: begin
            add(ChLsLead);
            if ($urandom_range(1)) add(8'h80);
            add("z");
          end
        endcase
      end
      9: begin
        add(ChLsLead);
        case ($urandom_range(3))
          0: begin
            add(8'h80);
            add($urandom_range(1) ? 8'hA8 : 8'hA9);
          end
          1: begin
            add(8'h80);
            add("x");
          end
          2: add("y");
          default: begin
            add(8'h82);
            add(8'hAC);
          end
        endcase
      end
      10: begin
        add(8'hC3);
        add(8'hA9);
      end
      default: begin
        add(ChBslash);
        add("u");
        add("{");
        add("D");
        add("8");
        add("3");
        add("D");
        add("}");
        add_u4(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end
    endcase
  endtask

  task automatic add_string();
    logic [7:0] q;
    q = $urandom_range(1) ? ChApos : ChQuote;
    if ($urandom_range(19) == 0) add(8'($urandom_range(255)));
    add(q);
    repeat ($urandom_range(1, 6)) add_piece();
    case ($urandom_range(19))
      0: add_end_of_text();
      1: ;
      default: add(q);
    endcase
    if ($urandom_range(9) == 0) add_end_of_text();
  endtask

  task automatic random_phase(int unsigned target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      add_string();
      drain_source();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: surrogate pair, \xFF, control escape, held E2 80 that falls back
    // to data, a stray byte and end of text while idle, and end of text inside.
    add(ChQuote);
    add_u4(16'hD83D);
    add_u4(16'hDE00);
    add(ChBslash);
    add("x");
    add("F");
    add("F");
    add(ChBslash);
    add("b");
    add(ChLsLead);
    add(8'h80);
    add("a");
    add(ChApos);
    add(ChQuote);
    add_end_of_text();
    add(8'hFF);
    add(ChApos);
    add(8'h00);
    add_end_of_text();
    drain_source();

    send_idle_pct = 10;
    recv_idle_pct = 73;
    random_phase(100);
    send_idle_pct = 73;
    recv_idle_pct = 10;
    random_phase(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Long receiver hold-off while bytes keep coming, so the queue fills.
    hold_request = 1;
    random_phase(100);

    push <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/jslu_pkg.sv
rtl/core/jslu_fifo.sv
rtl/core/jslu_front.sv
rtl/core/jslu_back.sv
rtl/core/js_string_literal_unescaper.sv
rtl/core/jslu_checker.sv
tb/tb_js_string_literal_unescaper.sv
